// ===== hdl/gregorian_date_adder_macros.svh =====
// Assertion macros shared by the date adder.
`ifndef GREGORIAN_DATE_ADDER_MACROS_SVH
`define GREGORIAN_DATE_ADDER_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define GDA_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("gregorian_date_adder: same-cycle check failed");

// The property must hold in the cycle after the condition.
`define GDA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("gregorian_date_adder: next-cycle check failed");

`endif

// ===== hdl/gda_pkg.sv =====
`timescale 1ns / 1ps

package gda_pkg;

   localparam logic [1:0] ACT_VALIDATE = 2'd0;
   localparam logic [1:0] ACT_YEARS    = 2'd1;
   localparam logic [1:0] ACT_MONTHS   = 2'd2;
   localparam logic [1:0] ACT_DAYS     = 2'd3;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_YEAR   = 3'd1;
   localparam logic [2:0] ST_MONTH  = 3'd2;
   localparam logic [2:0] ST_DAY    = 3'd3;
   localparam logic [2:0] ST_AMOUNT = 3'd4;

   localparam logic [13:0] YEAR_MIN = 14'd1900;
   localparam logic [13:0] YEAR_MAX = 14'd9999;

   localparam logic [3:0] JANUARY  = 4'd1;
   localparam logic [3:0] FEBRUARY = 4'd2;
   localparam logic [3:0] DECEMBER = 4'd12;

   localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
   localparam logic [4:0] FEB_LEN      = 5'd28;

   localparam logic signed [10:0] YEAR_STEP_MAX  = 11'sd2;
   localparam logic signed [10:0] MONTH_STEP_MAX = 11'sd24;
   localparam logic signed [10:0] DAY_STEP_MAX   = 11'sd730;

   // Year / 100 is taken as (year * 5243) >> 19, exact for every 14-bit year.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [14:0] CENTURY     = 15'd100;

   // Month lengths of a common year; codes above December read as zero.
   localparam logic [4:0] MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   typedef struct packed {
      logic [3:0]  month;
      logic [4:0]  day;
      logic [13:0] year;
      logic [2:0]  status;
   } gda_result_type;

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      if (month == FEBRUARY) begin
         len = leap ? FEB_LEAP_LEN : FEB_LEN;
      end else begin
         len = MONTH_LEN[month];
      end
      return len;
   endfunction

   function automatic logic [2:0] check_date(input logic [3:0] month, input logic [4:0] day,
                                             input logic [13:0] year, input logic leap);
      logic [2:0] st;
      if (year < YEAR_MIN || year > YEAR_MAX) begin
         st = ST_YEAR;
      end else if (month < JANUARY || month > DECEMBER) begin
         st = ST_MONTH;
      end else if (day == 5'd0 || day > days_in(month, leap)) begin
         st = ST_DAY;
      end else begin
         st = ST_OK;
      end
      return st;
   endfunction

endpackage

// ===== hdl/gda_leap.sv =====
`timescale 1ns / 1ps

module gda_leap import gda_pkg::*; (
   input  logic        clock,
   input  logic [13:0] year,
   output logic        leap
);

   logic [26:0] prod;
   logic [7:0]  cent_in;
   logic [7:0]  cent_ff;
   logic [13:0] year_ff;
   logic [14:0] cent_scaled;
   logic [13:0] rem;
   logic        leap_in;
   logic        leap_ff;

   assign prod    = {13'd0, year} * {14'd0, RECIP_100};
   assign cent_in = prod[RECIP_SHIFT +: 8];

   assign cent_scaled = {7'd0, cent_ff} * CENTURY;
   assign rem         = year_ff - cent_scaled[13:0];

   // Leap when divisible by 4 but not 100, or when divisible by 400.
   assign leap_in = ((year_ff[1:0] == 2'd0) && (rem != 14'd0)) ||
                    ((rem == 14'd0) && (cent_ff[1:0] == 2'd0));

   always_ff @(posedge clock) begin
      cent_ff <= cent_in;
      year_ff <= year;
      leap_ff <= leap_in;
   end

   assign leap = leap_ff;

endmodule

// ===== hdl/gda_ctrl.sv =====
`timescale 1ns / 1ps

module gda_ctrl import gda_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [3:0]            req_in_month,
   input  logic [4:0]            req_in_day,
   input  logic [13:0]           req_in_year,
   input  logic signed [10:0]    req_amount,
   input  logic                  slot_free,
   output logic                  done,
   output gda_result_type        result
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_LEAP_A   = 6'b000010,
      S_LEAP_B   = 6'b000100,
      S_CHECK_IN = 6'b001000,
      S_STEP     = 6'b010000,
      S_FINAL    = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   state_type          ret_ff, ret_in;
   logic [1:0]         action_ff, action_in;
   logic [3:0]         month_ff, month_in;
   logic [4:0]         day_ff, day_in;
   logic [13:0]        year_ff, year_in;
   logic signed [10:0] amount_ff, amount_in;
   logic [2:0]         status_ff, status_in;
   logic [9:0]         count_ff, count_in;
   logic               down_ff, down_in;

   logic               leap;
   logic [4:0]         dim;
   logic [2:0]         start_st;
   logic [5:0]         mt;
   logic [2:0]         mq;
   logic [5:0]         mr;
   logic [10:0]        magnitude;
   logic [4:0]         day_fix;
   logic [2:0]         final_st;

   gda_leap u_leap (
      .clock (clock),
      .year  (year_ff),
      .leap  (leap)
   );

   assign dim      = days_in(month_ff, leap);
   assign start_st = check_date(month_ff, day_ff, year_ff, leap);

   // Zero-based target month plus two years of bias, 0 to 59 for every amount within MONTH_STEP_MAX.
   assign mt = {2'b00, month_ff} + amount_ff[5:0] + 6'd23;

   always_comb begin
      if (mt >= 6'd48) begin
         mq = 3'd4;
      end else if (mt >= 6'd36) begin
         mq = 3'd3;
      end else if (mt >= 6'd24) begin
         mq = 3'd2;
      end else if (mt >= 6'd12) begin
         mq = 3'd1;
      end else begin
         mq = 3'd0;
      end
   end

   assign mr        = mt - ({3'd0, mq} * 6'd12);
   assign magnitude = amount_ff[10] ? (~amount_ff + 11'd1) : amount_ff;

   assign day_fix  = ((action_ff == ACT_MONTHS) && (day_ff > dim)) ? dim : day_ff;
   assign final_st = (status_ff != ST_OK) ? status_ff
                                          : check_date(month_ff, day_fix, year_ff, leap);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      action_in = action_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      year_in   = year_ff;
      amount_in = amount_ff;
      status_in = status_ff;
      count_in  = count_ff;
      down_in   = down_ff;
      done      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               action_in = req_action;
               month_in  = req_in_month;
               day_in    = req_in_day;
               year_in   = req_in_year;
               amount_in = req_amount;
               status_in = ST_OK;
               ret_in    = S_CHECK_IN;
               state_in  = S_LEAP_A;
            end
         end
         S_LEAP_A: begin
            state_in = S_LEAP_B;
         end
         S_LEAP_B: begin
            state_in = ret_ff;
         end
         S_CHECK_IN: begin
            state_in = S_FINAL;
            if (start_st != ST_OK) begin
               status_in = start_st;
            end else begin
               case (action_ff)
                  ACT_YEARS: begin
                     if (amount_ff > YEAR_STEP_MAX || amount_ff < -YEAR_STEP_MAX) begin
                        status_in = ST_AMOUNT;
                     end else begin
                        year_in  = year_ff + {{3{amount_ff[10]}}, amount_ff};
                        ret_in   = S_FINAL;
                        state_in = S_LEAP_A;
                     end
                  end
                  ACT_MONTHS: begin
                     if (amount_ff > MONTH_STEP_MAX || amount_ff < -MONTH_STEP_MAX) begin
                        status_in = ST_AMOUNT;
                     end else begin
                        month_in = mr[3:0] + 4'd1;
                        year_in  = year_ff + {11'd0, mq} - 14'd2;
                        ret_in   = S_FINAL;
                        state_in = S_LEAP_A;
                     end
                  end
                  ACT_DAYS: begin
                     if (amount_ff > DAY_STEP_MAX || amount_ff < -DAY_STEP_MAX) begin
                        status_in = ST_AMOUNT;
                     end else begin
                        count_in = magnitude[9:0];
                        down_in  = amount_ff[10];
                        state_in = S_STEP;
                     end
                  end
                  default: begin
                     state_in = S_FINAL;
                  end
               endcase
            end
         end
         S_STEP: begin
            if (count_ff == 10'd0) begin
               state_in = S_FINAL;
            end else begin
               count_in = count_ff - 10'd1;
               if (!down_ff) begin
                  if (day_ff >= dim) begin
                     day_in = 5'd1;
                     if (month_ff == DECEMBER) begin
                        month_in = JANUARY;
                        year_in  = year_ff + 14'd1;
                        ret_in   = S_STEP;
                        state_in = S_LEAP_A;
                     end else begin
                        month_in = month_ff + 4'd1;
                     end
                  end else begin
                     day_in = day_ff + 5'd1;
                  end
               end else begin
                  if (day_ff == 5'd1) begin
                     if (month_ff == JANUARY) begin
                        month_in = DECEMBER;
                        day_in   = MONTH_LEN[DECEMBER];
                        year_in  = year_ff - 14'd1;
                        ret_in   = S_STEP;
                        state_in = S_LEAP_A;
                     end else begin
                        month_in = month_ff - 4'd1;
                        day_in   = days_in(month_ff - 4'd1, leap);
                     end
                  end else begin
                     day_in = day_ff - 5'd1;
                  end
               end
            end
         end
         S_FINAL: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_CHECK_IN;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
      action_ff <= action_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      year_ff   <= year_in;
      amount_ff <= amount_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      down_ff   <= down_in;
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      if (final_st == ST_OK) begin
         result.month = month_ff;
         result.day   = day_fix;
         result.year  = year_ff;
      end else begin
         result.month = 4'd0;
         result.day   = 5'd0;
         result.year  = 14'd0;
      end
      result.status = final_st;
   end

endmodule

// ===== hdl/gregorian_date_adder.sv =====
// Gregorian date adder: each word accepted on req_ carries a month/day/year date, a signed
// amount and an action (validate, add years, add months, add days) and yields exactly one
// word on rsp_ with the new date and a status; the date fields are zero whenever the status
// is not ok. The block works on one word at a time and drops req_ready from acceptance until
// its result is handed to the output register. Validate and error cases pass through the
// leap states, the input check and the final state; year and month adds pass through the
// leap states once more after the check; a day add steps once per unit of |amount| and
// passes through the leap states again at every year boundary. The day add walks the
// calendar one day per cycle, pausing at each new year for the registered leap-year unit.
// A finished result waits in the output register while the next word is accepted.
`timescale 1ns / 1ps
`include "gregorian_date_adder_macros.svh"

module gregorian_date_adder import gda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_in_month,
   input  logic [4:0]         req_in_day,
   input  logic [13:0]        req_in_year,
   input  logic signed [10:0] req_amount,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_out_month,
   output logic [4:0]         rsp_out_day,
   output logic [13:0]        rsp_out_year,
   output logic [2:0]         rsp_status
);

   logic           slot_free;
   logic           done;
   gda_result_type result;
   gda_result_type result_ff, result_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           date_zero;
   logic           date_legal;

   gda_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_in_month (req_in_month),
      .req_in_day   (req_in_day),
      .req_in_year  (req_in_year),
      .req_amount   (req_amount),
      .slot_free    (slot_free),
      .done         (done),
      .result       (result)
   );

   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);
   assign result_in    = done ? result : result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_month = result_ff.month;
   assign rsp_out_day   = result_ff.day;
   assign rsp_out_year  = result_ff.year;
   assign rsp_status    = result_ff.status;

   assign date_zero  = (rsp_out_month == 4'd0) && (rsp_out_day == 5'd0) &&
                       (rsp_out_year == 14'd0);
   assign date_legal = (rsp_out_month >= JANUARY) && (rsp_out_month <= DECEMBER) &&
                       (rsp_out_day != 5'd0) && (rsp_out_year >= YEAR_MIN) &&
                       (rsp_out_year <= YEAR_MAX);

   `GDA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `GDA_ASSERT_NOW(a_error_zeroes_date, clock, reset, rsp_valid && rsp_status != ST_OK, date_zero)
   `GDA_ASSERT_NOW(a_ok_date_in_range, clock, reset, rsp_valid && rsp_status == ST_OK, date_legal)
   `GDA_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status <= ST_AMOUNT)

endmodule
